FILE: design/sts_pkg.sv
// Shared types, constants and helper functions for the sphere triangle subdivider.
// No dependencies; every other design file but sts_checker refers to this package by scoped names.
package sts_pkg;

    // Default number of fraction bits of the coordinate format.
    localparam int FRAC_BITS_DEF = 14;

    // Width of one coordinate field.
    localparam int CW = 16;

    // Edge components are one bit wider than a coordinate.
    localparam int EW = CW + 1;

    // Widest vector handed to a normalizer: a cross product component.
    localparam int NORM_IW = 2 * EW + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBDIV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 2'd1;

    // Vertex codes: corners a, b, c and edge midpoints ab, bc, ca.
    localparam int VTX_W = 3;
    localparam logic [VTX_W-1:0] VTX_A  = 3'd0;
    localparam logic [VTX_W-1:0] VTX_B  = 3'd1;
    localparam logic [VTX_W-1:0] VTX_C  = 3'd2;
    localparam logic [VTX_W-1:0] VTX_AB = 3'd3;
    localparam logic [VTX_W-1:0] VTX_BC = 3'd4;
    localparam logic [VTX_W-1:0] VTX_CA = 3'd5;
    localparam int NUM_VTX = 6;

    // Output triangles per input and corners per triangle.
    localparam int NUM_TRI = 4;
    localparam logic [1:0] TRI_LAST    = 2'd3;
    localparam logic [1:0] CORNER_LAST = 2'd2;

    typedef logic [CW-1:0] coord_t;
    typedef coord_t [2:0] vec3_t;                 // element 0 is x
    typedef logic [NORM_IW-1:0] wide_t;
    typedef wide_t [2:0] cross_t;                 // element 0 is x

    typedef struct packed {
        logic smooth;
        logic subdiv;
    } mode_t;

    localparam int MODE_W = 2;

    // Sign extension of a coordinate to normalizer width.
    function automatic wide_t sext_coord(input coord_t v);
        return {{(NORM_IW - CW){v[CW-1]}}, v};
    endfunction

    // Which vertex sits at a given corner of a given output triangle.
    function automatic logic [VTX_W-1:0] vert_sel(input logic subdiv,
                                                   input logic [1:0] tri_idx,
                                                   input logic [1:0] corner);
        logic [VTX_W-1:0] c0;
        logic [VTX_W-1:0] c1;
        logic [VTX_W-1:0] c2;
        logic [VTX_W-1:0] code;
        c0 = VTX_A;
        c1 = VTX_B;
        c2 = VTX_C;
        if (subdiv) begin
            unique case (tri_idx)
                2'd0: begin c0 = VTX_A;  c1 = VTX_AB; c2 = VTX_CA; end
                2'd1: begin c0 = VTX_AB; c1 = VTX_B;  c2 = VTX_BC; end
                2'd2: begin c0 = VTX_CA; c1 = VTX_BC; c2 = VTX_C;  end
                default: begin c0 = VTX_AB; c1 = VTX_BC; c2 = VTX_CA; end
            endcase
        end
        case (corner)
            2'd0:    code = c0;
            2'd1:    code = c1;
            default: code = c2;
        endcase
        return code;
    endfunction

endpackage

FILE: design/sts_norm.sv
// Pipelined vector normalizer: scale, sum of squares, square root and three dividers.
// Depends on sts_pkg.
module sts_norm #(
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF,
    parameter int IW        = sts_pkg::NORM_IW,
    parameter int SW        = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [IW-1:0]       in_x,
    input  logic signed [IW-1:0]       in_y,
    input  logic signed [IW-1:0]       in_z,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic signed [sts_pkg::CW-1:0] out_x,
    output logic signed [sts_pkg::CW-1:0] out_y,
    output logic signed [sts_pkg::CW-1:0] out_z,
    output logic [SW-1:0]              out_side
);

    localparam int CW    = sts_pkg::CW;
    localparam int NW    = 20;
    localparam int TOP   = NW - 1;
    localparam int PW    = $clog2(IW);
    localparam int SQW   = 2 * NW + 2;
    localparam int SQI   = SQW / 2;
    localparam int RW    = SQI;
    localparam int REMW  = RW + 3;
    localparam int SQ_ST = (SQI + 1) / 2;
    localparam int QW    = FRAC_BITS + 1;
    localparam int DW    = NW + FRAC_BITS + 1;
    localparam int DV_ST = (QW + 1) / 2;
    localparam int CTXW  = 3 * NW + 4 + SW;
    localparam logic [QW-1:0] CAP = (FRAC_BITS >= 15) ? QW'(32767) : (QW'(1) << FRAC_BITS);

    // Stage 1: magnitudes, signs and largest magnitude.
    logic [IW-1:0] vin  [3];
    logic [IW-1:0] mag1 [3];
    logic [2:0]    neg1;
    logic [IW-1:0] max1;

    always_comb
    begin
        vin[0] = in_x;
        vin[1] = in_y;
        vin[2] = in_z;
        max1 = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg1[i] = vin[i][IW-1];
            mag1[i] = neg1[i] ? (~vin[i] + IW'(1)) : vin[i];
            if (mag1[i] > max1)
            begin
                max1 = mag1[i];
            end
        end
    end

    logic [IW-1:0] s1_mag_reg [3];
    logic [2:0]    s1_neg_reg;
    logic [IW-1:0] s1_max_reg;
    logic [SW-1:0] s1_side_reg;
    logic          s1_v_reg;

    // Stage 2: position of the leading one of the largest magnitude.
    logic [PW-1:0] p2;

    always_comb
    begin
        p2 = '0;
        for (int k = 0; k < IW; k++)
        begin
            if (s1_max_reg[k])
            begin
                p2 = PW'(k);
            end
        end
    end

    logic [IW-1:0] s2_mag_reg [3];
    logic [2:0]    s2_neg_reg;
    logic          s2_zero_reg;
    logic [PW-1:0] s2_p_reg;
    logic [SW-1:0] s2_side_reg;
    logic          s2_v_reg;

    // Stage 3: shift all three so that the largest lies in [2^19, 2^20).
    logic [NW-1:0] a3 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (s2_p_reg >= PW'(TOP))
            begin
                a3[i] = NW'(s2_mag_reg[i] >> (s2_p_reg - PW'(TOP)));
            end
            else
            begin
                a3[i] = NW'(s2_mag_reg[i] << (PW'(TOP) - s2_p_reg));
            end
        end
    end

    logic [CTXW-1:0] s3_ctx_reg;
    logic            s3_v_reg;

    // Stage 4: squares.
    logic [2*NW-1:0] sq4 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq4[i] = {{NW{1'b0}}, s3_ctx_reg[i*NW +: NW]} * {{NW{1'b0}}, s3_ctx_reg[i*NW +: NW]};
        end
    end

    logic [2*NW-1:0] s4_sq_reg [3];
    logic [CTXW-1:0] s4_ctx_reg;
    logic            s4_v_reg;

    // Square root: two result bits per stage; entry 0 is loaded with the sum.
    logic [SQW-1:0]  sq_x_reg    [SQ_ST+1];
    logic [REMW-1:0] sq_rem_reg  [SQ_ST+1];
    logic [RW-1:0]   sq_root_reg [SQ_ST+1];
    logic [CTXW-1:0] sq_ctx_reg  [SQ_ST+1];
    logic            sq_v_reg    [SQ_ST+1];

    // Division: two quotient bits per stage; entry 0 holds the numerators.
    logic [DW-1:0]   dv_rem_reg [DV_ST+1][3];
    logic [QW-1:0]   dv_q_reg   [DV_ST+1][3];
    logic [RW-1:0]   dv_len_reg [DV_ST+1];
    logic [CTXW-1:0] dv_ctx_reg [DV_ST+1];
    logic            dv_v_reg   [DV_ST+1];

    logic [CW-1:0]   o_reg [3];
    logic [SW-1:0]   o_side_reg;
    logic            o_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            sq_v_reg[0] <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            o_v_reg     <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg    <= in_valid;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            sq_v_reg[0] <= s4_v_reg;
            dv_v_reg[0] <= sq_v_reg[SQ_ST];
            o_v_reg     <= dv_v_reg[DV_ST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_mag_reg[i] <= mag1[i];
                s2_mag_reg[i] <= s1_mag_reg[i];
                s4_sq_reg[i]  <= sq4[i];
            end
            s1_neg_reg  <= neg1;
            s1_max_reg  <= max1;
            s1_side_reg <= in_side;

            s2_neg_reg  <= s1_neg_reg;
            s2_zero_reg <= (s1_max_reg == '0);
            s2_p_reg    <= p2;
            s2_side_reg <= s1_side_reg;

            s3_ctx_reg  <= {s2_side_reg, s2_zero_reg, s2_neg_reg, a3[2], a3[1], a3[0]};
            s4_ctx_reg  <= s3_ctx_reg;

            sq_x_reg[0]    <= SQW'(s4_sq_reg[0]) + SQW'(s4_sq_reg[1]) + SQW'(s4_sq_reg[2]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_ctx_reg[0]  <= s4_ctx_reg;

            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= (DW'(sq_ctx_reg[SQ_ST][i*NW +: NW]) << FRAC_BITS)
                                    + DW'(sq_root_reg[SQ_ST] >> 1);
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0] <= sq_root_reg[SQ_ST];
            dv_ctx_reg[0] <= sq_ctx_reg[SQ_ST];
        end
    end

    genvar s;
    generate
        for (s = 0; s < SQ_ST; s++)
        begin : g_sqrt
            logic [REMW-1:0] r;
            logic [REMW-1:0] t;
            logic [RW-1:0]   q;
            logic [SQW-1:0]  x;

            always_comb
            begin
                r = sq_rem_reg[s];
                q = sq_root_reg[s];
                x = sq_x_reg[s];
                t = '0;
                for (int k = 0; k < 2; k++)
                begin
                    if (2 * s + k < SQI)
                    begin
                        r = {r[REMW-3:0], x[SQW-1 -: 2]};
                        x = x << 2;
                        t = REMW'({q, 2'b01});
                        if (r >= t)
                        begin
                            r = r - t;
                            q = {q[RW-2:0], 1'b1};
                        end
                        else
                        begin
                            q = {q[RW-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_v_reg[s+1] <= 1'b0;
                end
                else if (en)
                begin
                    sq_v_reg[s+1] <= sq_v_reg[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[s+1]  <= r;
                    sq_root_reg[s+1] <= q;
                    sq_x_reg[s+1]    <= x;
                    sq_ctx_reg[s+1]  <= sq_ctx_reg[s];
                end
            end
        end

        for (s = 0; s < DV_ST; s++)
        begin : g_div
            logic [DW-1:0] r [3];
            logic [QW-1:0] q [3];
            logic [DW-1:0] dsh;

            always_comb
            begin
                dsh = '0;
                for (int i = 0; i < 3; i++)
                begin
                    r[i] = dv_rem_reg[s][i];
                    q[i] = dv_q_reg[s][i];
                    for (int k = 0; k < 2; k++)
                    begin
                        if (2 * s + k < QW)
                        begin
                            dsh = DW'(dv_len_reg[s]) << (QW - 1 - 2 * s - k);
                            if (r[i] >= dsh)
                            begin
                                r[i] = r[i] - dsh;
                                q[i] = {q[i][QW-2:0], 1'b1};
                            end
                            else
                            begin
                                q[i] = {q[i][QW-2:0], 1'b0};
                            end
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[s+1] <= 1'b0;
                end
                else if (en)
                begin
                    dv_v_reg[s+1] <= dv_v_reg[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dv_rem_reg[s+1][i] <= r[i];
                        dv_q_reg[s+1][i]   <= q[i];
                    end
                    dv_len_reg[s+1] <= dv_len_reg[s];
                    dv_ctx_reg[s+1] <= dv_ctx_reg[s];
                end
            end
        end
    endgenerate

    // Final stage: clamp, restore sign, force zero for a null vector.
    logic [CW-1:0] o_next [3];
    logic [QW-1:0] qc;
    logic [CW-1:0] m16;
    logic [2:0]    negf;
    logic          zerof;

    always_comb
    begin
        negf  = dv_ctx_reg[DV_ST][3*NW +: 3];
        zerof = dv_ctx_reg[DV_ST][3*NW+3];
        qc    = '0;
        m16   = '0;
        for (int i = 0; i < 3; i++)
        begin
            qc  = (dv_q_reg[DV_ST][i] > CAP) ? CAP : dv_q_reg[DV_ST][i];
            m16 = CW'(qc);
            if (zerof)
            begin
                o_next[i] = '0;
            end
            else if (negf[i])
            begin
                o_next[i] = ~m16 + CW'(1);
            end
            else
            begin
                o_next[i] = m16;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o_reg[i] <= o_next[i];
            end
            o_side_reg <= dv_ctx_reg[DV_ST][3*NW+4 +: SW];
        end
    end

    assign out_valid = o_v_reg;
    assign out_x     = o_reg[0];
    assign out_y     = o_reg[1];
    assign out_z     = o_reg[2];
    assign out_side  = o_side_reg;

endmodule

FILE: design/sts_cross.sv
// Face cross products of the four output triangles in three register stages.
// Depends on sts_pkg.
module sts_cross #(
    parameter int SW = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  sts_pkg::mode_t          mode,
    input  sts_pkg::vec3_t [5:0]    verts,
    input  logic [SW-1:0]           in_side,
    output logic                    out_valid,
    output sts_pkg::cross_t [3:0]   cr,
    output logic [SW-1:0]           out_side
);

    localparam int EW = sts_pkg::EW;
    localparam int PW = 2 * EW;
    localparam int NI = sts_pkg::NORM_IW;

    logic signed [EW-1:0] e1 [4][3];
    logic signed [EW-1:0] e2 [4][3];
    sts_pkg::vec3_t p0, p1, p2;

    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            p0 = verts[sts_pkg::vert_sel(mode.subdiv, 2'(t), 2'd0)];
            p1 = verts[sts_pkg::vert_sel(mode.subdiv, 2'(t), 2'd1)];
            p2 = verts[sts_pkg::vert_sel(mode.subdiv, 2'(t), 2'd2)];
            for (int i = 0; i < 3; i++)
            begin
                e1[t][i] = $signed({p1[i][EW-2], p1[i]}) - $signed({p0[i][EW-2], p0[i]});
                e2[t][i] = $signed({p2[i][EW-2], p2[i]}) - $signed({p0[i][EW-2], p0[i]});
            end
        end
    end

    logic signed [EW-1:0] e1_reg [4][3];
    logic signed [EW-1:0] e2_reg [4][3];
    logic signed [PW-1:0] pr_reg [4][6];
    logic [NI-1:0]        c_reg  [4][3];
    logic [SW-1:0]        side1_reg, side2_reg, side3_reg;
    logic                 v1_reg, v2_reg, v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 4; t++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[t][i] <= e1[t][i];
                    e2_reg[t][i] <= e2[t][i];
                end
                pr_reg[t][0] <= e1_reg[t][1] * e2_reg[t][2];
                pr_reg[t][1] <= e1_reg[t][2] * e2_reg[t][1];
                pr_reg[t][2] <= e1_reg[t][2] * e2_reg[t][0];
                pr_reg[t][3] <= e1_reg[t][0] * e2_reg[t][2];
                pr_reg[t][4] <= e1_reg[t][0] * e2_reg[t][1];
                pr_reg[t][5] <= e1_reg[t][1] * e2_reg[t][0];
                for (int i = 0; i < 3; i++)
                begin
                    c_reg[t][i] <= NI'($signed({pr_reg[t][2*i][PW-1], pr_reg[t][2*i]})
                                 - $signed({pr_reg[t][2*i+1][PW-1], pr_reg[t][2*i+1]}));
                end
            end
            side1_reg <= in_side;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
        end
    end

    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cr[t][i] = c_reg[t][i];
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;

endmodule

FILE: design/sts_serial.sv
// Output serializer: holds one finished triangle and sends its vertices one per cycle while m_tready is high.
// Depends on sts_pkg.
module sts_serial (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  sts_pkg::mode_t               in_mode,
    input  sts_pkg::vec3_t [5:0]         in_pos,
    input  sts_pkg::vec3_t [3:0]         in_fn,
    output logic                         take,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [6*sts_pkg::CW-1:0]     m_tdata,
    output logic                         m_tlast
);

    sts_pkg::vec3_t [5:0] pos_reg;
    sts_pkg::vec3_t [3:0] fn_reg;
    sts_pkg::mode_t       mode_reg;
    logic [1:0]           tri_cnt_reg;
    logic [1:0]           corner_reg;
    logic                 busy_reg;

    logic [sts_pkg::VTX_W-1:0] code;
    sts_pkg::vec3_t            pos;
    sts_pkg::vec3_t            nrm;
    logic                      last;
    logic                      fire;

    always_comb
    begin
        code = sts_pkg::vert_sel(mode_reg.subdiv, tri_cnt_reg, corner_reg);
        pos  = pos_reg[code];
        nrm  = mode_reg.smooth ? pos : fn_reg[tri_cnt_reg];
        last = (corner_reg == sts_pkg::CORNER_LAST)
               && ((tri_cnt_reg == sts_pkg::TRI_LAST) || !mode_reg.subdiv);
    end

    assign fire     = busy_reg && m_tready;
    assign take     = in_valid && (!busy_reg || (fire && last));
    assign m_tvalid = busy_reg;
    assign m_tdata  = {nrm, pos};
    assign m_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            tri_cnt_reg <= '0;
            corner_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg    <= 1'b1;
            tri_cnt_reg <= '0;
            corner_reg  <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else if (corner_reg == sts_pkg::CORNER_LAST)
            begin
                corner_reg  <= '0;
                tri_cnt_reg <= tri_cnt_reg + 2'd1;
            end
            else
            begin
                corner_reg <= corner_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pos_reg  <= in_pos;
            fn_reg   <= in_fn;
            mode_reg <= in_mode;
        end
    end

endmodule

FILE: design/sphere_triangle_subdivider.sv
// Top level of the sphere triangle subdivider.
// Depends on sts_pkg, sts_norm, sts_cross and sts_serial.

// One input request carries a triangle of three Q1.14 vertices; the block returns its
// vertices with normals, one output request per vertex, m_tlast marking the last vertex
// of the triangle. With subdivide_mode set, each edge midpoint is pushed onto the
// unit sphere and four triangles (a,ab,ca), (ab,b,bc), (ca,bc,c), (ab,bc,ca) come out,
// twelve vertices; otherwise the input triangle comes out as three vertices. Normals are
// the position itself when smooth_normals is set and the normalized face cross product
// otherwise; a degenerate face or opposite edge endpoints give a zero vector. The work is
// a fully pipelined datapath: three midpoint normalizers, a three-stage cross product
// unit and four face normalizers, each normalizer 26 stages deep at FRAC_BITS of 14
// (one square root stage per two root bits, one divider stage per two quotient bits).
// A new triangle can enter every cycle the pipeline moves; the sustained rate is set by
// the output port, which sends one vertex per cycle while m_tready is high: twelve
// vertices per triangle when subdividing, three otherwise. The whole pipeline holds
// while a finished triangle waits for the output, so no request is lost under
// back-pressure. Configuration writes take effect at once and are meant to be issued
// while no triangle is in flight.
module sphere_triangle_subdivider #(
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up, 16 bits each
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [9*sts_pkg::CW-1:0]      s_tdata,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z from the lowest bit up, 16 bits each
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [6*sts_pkg::CW-1:0]      m_tdata,
    output logic                          m_tlast,       // last_vertex
    input  logic                          cfg_we,
    input  logic [sts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [0:0]                    cfg_data
);

    localparam int CW     = sts_pkg::CW;
    localparam int MW     = sts_pkg::MODE_W;
    localparam int MID_SW = MW + 3 * 3 * CW;
    localparam int CR_SW  = MW + sts_pkg::NUM_VTX * 3 * CW;

    // Configuration registers.
    logic subdiv_reg;
    logic smooth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subdiv_reg <= 1'b1;
            smooth_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sts_pkg::CFG_SUBDIV: subdiv_reg <= cfg_data[0];
                sts_pkg::CFG_SMOOTH: smooth_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The whole datapath moves together; it holds only when a finished triangle sits at
    // its end and the serializer cannot take it yet.
    logic en;
    logic take;
    logic end_valid;

    assign en       = !end_valid || take;
    assign s_tready = en;

    // Input vertices.
    sts_pkg::vec3_t va, vb, vc;
    sts_pkg::mode_t mode_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            va[i] = s_tdata[CW*i       +: CW];
            vb[i] = s_tdata[CW*(3 + i) +: CW];
            vc[i] = s_tdata[CW*(6 + i) +: CW];
        end
        mode_in.subdiv = subdiv_reg;
        mode_in.smooth = smooth_reg;
    end

    // Edge sums; halving is skipped since it does not change the direction.
    sts_pkg::cross_t s_ab, s_bc, s_ca;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_ab[i] = sts_pkg::sext_coord(va[i]) + sts_pkg::sext_coord(vb[i]);
            s_bc[i] = sts_pkg::sext_coord(vb[i]) + sts_pkg::sext_coord(vc[i]);
            s_ca[i] = sts_pkg::sext_coord(vc[i]) + sts_pkg::sext_coord(va[i]);
        end
    end

    // Midpoint normalizers; the first one carries the corners and the mode along.
    logic                 mid_valid;
    logic [MID_SW-1:0]    mid_side;
    sts_pkg::vec3_t       m_ab, m_bc, m_ca;

    sts_norm #(.FRAC_BITS(FRAC_BITS), .IW(sts_pkg::NORM_IW), .SW(MID_SW)) u_mid_ab (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_x     (s_ab[0]),
        .in_y     (s_ab[1]),
        .in_z     (s_ab[2]),
        .in_side  ({mode_in, vc, vb, va}),
        .out_valid(mid_valid),
        .out_x    (m_ab[0]),
        .out_y    (m_ab[1]),
        .out_z    (m_ab[2]),
        .out_side (mid_side)
    );

    sts_norm #(.FRAC_BITS(FRAC_BITS), .IW(sts_pkg::NORM_IW), .SW(1)) u_mid_bc (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_x     (s_bc[0]),
        .in_y     (s_bc[1]),
        .in_z     (s_bc[2]),
        .in_side  (1'b0),
        .out_valid(),
        .out_x    (m_bc[0]),
        .out_y    (m_bc[1]),
        .out_z    (m_bc[2]),
        .out_side ()
    );

    sts_norm #(.FRAC_BITS(FRAC_BITS), .IW(sts_pkg::NORM_IW), .SW(1)) u_mid_ca (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_x     (s_ca[0]),
        .in_y     (s_ca[1]),
        .in_z     (s_ca[2]),
        .in_side  (1'b0),
        .out_valid(),
        .out_x    (m_ca[0]),
        .out_y    (m_ca[1]),
        .out_z    (m_ca[2]),
        .out_side ()
    );

    // All six vertices in code order, plus the mode captured with the request.
    sts_pkg::vec3_t [5:0] verts;
    sts_pkg::mode_t       mid_mode;

    always_comb
    begin
        verts[sts_pkg::VTX_A]  = mid_side[0       +: 3*CW];
        verts[sts_pkg::VTX_B]  = mid_side[3*CW    +: 3*CW];
        verts[sts_pkg::VTX_C]  = mid_side[6*CW    +: 3*CW];
        verts[sts_pkg::VTX_AB] = m_ab;
        verts[sts_pkg::VTX_BC] = m_bc;
        verts[sts_pkg::VTX_CA] = m_ca;
        mid_mode = sts_pkg::mode_t'(mid_side[9*CW +: MW]);
    end

    // Face cross products.
    logic                   cr_valid;
    sts_pkg::cross_t [3:0]  cr;
    logic [CR_SW-1:0]       cr_side;

    sts_cross #(.SW(CR_SW)) u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (mid_valid),
        .mode     (mid_mode),
        .verts    (verts),
        .in_side  ({mid_mode, verts}),
        .out_valid(cr_valid),
        .cr       (cr),
        .out_side (cr_side)
    );

    // Face normalizers; the first one carries the vertices and the mode along.
    sts_pkg::vec3_t [3:0] fn;
    logic [CR_SW-1:0]     end_side;

    genvar t;
    generate
        for (t = 0; t < sts_pkg::NUM_TRI; t++)
        begin : g_face
            if (t == 0)
            begin : g_lead
                sts_norm #(.FRAC_BITS(FRAC_BITS), .IW(sts_pkg::NORM_IW), .SW(CR_SW)) u_fn (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .en       (en),
                    .in_valid (cr_valid),
                    .in_x     (cr[t][0]),
                    .in_y     (cr[t][1]),
                    .in_z     (cr[t][2]),
                    .in_side  (cr_side),
                    .out_valid(end_valid),
                    .out_x    (fn[t][0]),
                    .out_y    (fn[t][1]),
                    .out_z    (fn[t][2]),
                    .out_side (end_side)
                );
            end
            else
            begin : g_rest
                sts_norm #(.FRAC_BITS(FRAC_BITS), .IW(sts_pkg::NORM_IW), .SW(1)) u_fn (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .en       (en),
                    .in_valid (cr_valid),
                    .in_x     (cr[t][0]),
                    .in_y     (cr[t][1]),
                    .in_z     (cr[t][2]),
                    .in_side  (1'b0),
                    .out_valid(),
                    .out_x    (fn[t][0]),
                    .out_y    (fn[t][1]),
                    .out_z    (fn[t][2]),
                    .out_side ()
                );
            end
        end
    endgenerate

    // Output serializer.
    sts_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (end_valid),
        .in_mode  (sts_pkg::mode_t'(end_side[CR_SW-1 -: MW])),
        .in_pos   (end_side[sts_pkg::NUM_VTX*3*CW-1:0]),
        .in_fn    (fn),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: design/sts_checker.sv
// Port-level checker for the sphere triangle subdivider, bound to the top level.
// Depends on the top level's port names only.
module sts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tlast,
    input logic [95:0] m_tdata
);

    logic [7:0] pend_reg;
    logic [3:0] vcnt_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            vcnt_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 8'(in_fire) - 8'(out_fire && m_tlast);
            if (out_fire)
            begin
                vcnt_reg <= m_tlast ? 4'd0 : vcnt_reg + 4'd1;
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 8'd0)
        else $error("vertex sent with no triangle outstanding");

    a_max_twelve: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && vcnt_reg == 4'd11 |-> m_tlast)
        else $error("triangle ran past twelve vertices");

    a_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && m_tlast |-> vcnt_reg == 4'd2 || vcnt_reg == 4'd11)
        else $error("triangle ended after an unexpected vertex count");

endmodule

bind sphere_triangle_subdivider sts_checker u_sts_checker (.*);

FILE: bench/sphere_triangle_subdivider_tb.sv
// Self-checking testbench for sphere_triangle_subdivider: directed and random triangles
// under all mode settings, random stalls on both streams, results checked vertex by vertex.
// Depends on sts_pkg and the sphere_triangle_subdivider RTL.
module sphere_triangle_subdivider_tb;

    localparam int CW = sts_pkg::CW;
    localparam int FRAC = sts_pkg::FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;
    // Latency of the datapath plus margin; used before mode changes and at the end.
    localparam int DRAIN_CYCLES = 120;
    // Index with no register behind it; writes there must be ignored.
    localparam logic [sts_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef sts_pkg::vec3_t vec3_t;
    typedef logic [9*CW-1:0] tri_bits_t;

    typedef struct {
        vec3_t pos;
        vec3_t norm;
        logic  last;
    } vertex_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    tri_bits_t s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [6*CW-1:0] m_tdata;
    logic m_tlast;
    logic cfg_we;
    logic [sts_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [0:0] cfg_data;

    // Triangles waiting to be sent and vertices the block still owes us.
    tri_bits_t tri_pending_q[$];
    vertex_t vertex_due_q[$];

    // Our own copy of the two mode registers.
    logic subdiv_on;
    logic smooth_on;

    int errors;
    int tris_sent;
    int verts_seen;
    int idle_cycles;
    int send_gap;
    int recv_stall;

    sphere_triangle_subdivider dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Integer square root, floor, by the usual bit-pair method.
    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Scale a vector to unit length in fixed point. The magnitudes are first brought
    // into [2^19, 2^20) together so the root and the divisions keep enough precision.
    function automatic vec3_t unit_vec(input longint vx, input longint vy, input longint vz);
        longint v[3];
        longint unsigned a[3];
        bit neg[3];
        longint unsigned m;
        longint unsigned l2;
        longint unsigned len;
        longint unsigned cap;
        longint unsigned q;
        longint t;
        vec3_t o;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        m = 0;
        o = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            a[i] = neg[i] ? -v[i] : v[i];
            if (a[i] > m)
                m = a[i];
        end
        if (m == 0)
            return o;
        while (m >= (64'd1 << 20))
        begin
            for (int i = 0; i < 3; i++)
                a[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 19))
        begin
            for (int i = 0; i < 3; i++)
                a[i] <<= 1;
            m <<= 1;
        end
        l2 = 0;
        for (int i = 0; i < 3; i++)
            l2 += a[i] * a[i];
        len = root64(l2);
        cap = 64'd1 << FRAC;
        if (cap > 32767)
            cap = 32767;
        for (int i = 0; i < 3; i++)
        begin
            q = ((a[i] << FRAC) + (len >> 1)) / len;
            if (q > cap)
                q = cap;
            t = neg[i] ? -longint'(q) : longint'(q);
            o[i] = t[CW-1:0];
        end
        return o;
    endfunction

    // Queue the three vertices of one output face with their normals.
    task automatic queue_face(input vec3_t p0, input vec3_t p1, input vec3_t p2,
                              input logic closes);
        vec3_t pv[3];
        longint e1[3];
        longint e2[3];
        vec3_t face_n;
        vertex_t vtx;
        pv[0] = p0;
        pv[1] = p1;
        pv[2] = p2;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'($signed(p1[i])) - longint'($signed(p0[i]));
            e2[i] = longint'($signed(p2[i])) - longint'($signed(p0[i]));
        end
        face_n = unit_vec(e1[1] * e2[2] - e1[2] * e2[1],
                          e1[2] * e2[0] - e1[0] * e2[2],
                          e1[0] * e2[1] - e1[1] * e2[0]);
        for (int j = 0; j < 3; j++)
        begin
            vtx.pos = pv[j];
            vtx.norm = smooth_on ? pv[j] : face_n;
            vtx.last = closes && (j == 2);
            vertex_due_q.insert(vertex_due_q.size(), vtx);
        end
    endtask

    // Append one triangle to the list of pending requests.
    task automatic add_tri(input tri_bits_t t);
        tri_pending_q.insert(tri_pending_q.size(), t);
    endtask

    // Midpoint of an edge pushed onto the sphere; halving is skipped since it
    // does not change the direction.
    function automatic vec3_t edge_mid(input vec3_t p, input vec3_t q);
        return unit_vec(longint'($signed(p[0])) + longint'($signed(q[0])),
                        longint'($signed(p[1])) + longint'($signed(q[1])),
                        longint'($signed(p[2])) + longint'($signed(q[2])));
    endfunction

    task automatic predict_vertices(input tri_bits_t t);
        vec3_t va;
        vec3_t vb;
        vec3_t vc;
        vec3_t mab;
        vec3_t mbc;
        vec3_t mca;
        va = t[3*CW-1:0];
        vb = t[6*CW-1:3*CW];
        vc = t[9*CW-1:6*CW];
        if (!subdiv_on)
            queue_face(va, vb, vc, 1'b1);
        else
        begin
            mab = edge_mid(va, vb);
            mbc = edge_mid(vb, vc);
            mca = edge_mid(vc, va);
            queue_face(va, mab, mca, 1'b0);
            queue_face(mab, vb, mbc, 1'b0);
            queue_face(mca, mbc, vc, 1'b0);
            queue_face(mab, mbc, mca, 1'b1);
        end
    endtask

    // Gap or stall length: mostly none, so long back-to-back stretches occur;
    // otherwise a uniform random draw.
    function automatic int draw_wait();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    endfunction

    // Request driver: holds a request until it is taken, then waits its drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_vertices(s_tdata);
                tris_sent++;
            end
            if (s_tvalid && !s_tready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (tri_pending_q.size() > 0)
            begin
                s_tdata <= tri_pending_q.pop_front();
                s_tvalid <= 1'b1;
                send_gap = draw_wait();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output monitor: compares each taken vertex with the oldest one predicted,
    // and throttles m_tready with random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t due;
        vec3_t got_pos;
        vec3_t got_norm;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                verts_seen++;
                got_pos = m_tdata[3*CW-1:0];
                got_norm = m_tdata[6*CW-1:3*CW];
                if (vertex_due_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: vertex with nothing expected: tdata %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    due = vertex_due_q.pop_front();
                    for (int i = 0; i < 3; i++)
                    begin
                        if (got_pos[i] !== due.pos[i])
                        begin
                            errors++;
                            $display("%0t: pos[%0d] expected %0d actual %0d", $time, i,
                                     $signed(due.pos[i]), $signed(got_pos[i]));
                        end
                        if (got_norm[i] !== due.norm[i])
                        begin
                            errors++;
                            $display("%0t: norm[%0d] expected %0d actual %0d", $time, i,
                                     $signed(due.norm[i]), $signed(got_norm[i]));
                        end
                    end
                    if (m_tlast !== due.last)
                    begin
                        errors++;
                        $display("%0t: last expected %b actual %b", $time, due.last,
                                 m_tlast);
                    end
                end
                recv_stall = draw_wait();
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: any cycle without a handshake on either side counts as idle.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("sphere_triangle_subdivider verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [sts_pkg::CFG_IDX_W-1:0] idx, input logic val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sts_pkg::CFG_SUBDIV)
            subdiv_on = val;
        else if (idx == sts_pkg::CFG_SMOOTH)
            smooth_on = val;
    endtask

    function automatic tri_bits_t make_tri(input int ax, input int ay, input int az,
                                           input int bx, input int by, input int bz,
                                           input int cx, input int cy, input int cz);
        tri_bits_t t;
        t = {cz[CW-1:0], cy[CW-1:0], cx[CW-1:0], bz[CW-1:0], by[CW-1:0], bx[CW-1:0],
             az[CW-1:0], ay[CW-1:0], ax[CW-1:0]};
        return t;
    endfunction

    // Random triangle: mostly coordinates within the unit range, with shared or
    // mirrored corners now and then, and some raw 16-bit noise.
    function automatic tri_bits_t random_tri();
        tri_bits_t t;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            t[i*CW +: CW] = kind == 9 ? CW'($urandom)
                                      : CW'($urandom_range(0, 32768) - 16384);
        if (kind == 7)
        begin
            // b opposite a, component by component
            for (int i = 0; i < 3; i++)
                t[(3 + i)*CW +: CW] = -t[i*CW +: CW];
        end
        else if (kind == 8)
            t[9*CW-1:6*CW] = t[6*CW-1:3*CW];     // c equals b
        return t;
    endfunction

    // Wait until every request has gone in and every vertex has come back,
    // then let the pipeline settle.
    task automatic drain();
        @(negedge clk);
        while (tri_pending_q.size() > 0 || s_tvalid || vertex_due_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int u;
        u = 1 << FRAC;
        errors = 0;
        tris_sent = 0;
        verts_seen = 0;
        idle_cycles = 0;
        subdiv_on = 1'b1;
        smooth_on = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sts_pkg::CFG_SUBDIV;
        cfg_data = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed triangles under the reset modes (subdivide, flat normals).
        add_tri(make_tri(u, 0, 0, 0, u, 0, 0, 0, u));
        add_tri(make_tri(-u, 0, 0, 0, -u, 0, 0, 0, -u));
        add_tri(make_tri(u, u, u, -u, -u, -u, 0, u, 0));  // opposite ends
        add_tri(make_tri(u, 0, 0, u, 0, 0, u, 0, 0));     // degenerate
        add_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_tri(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                         -1, 1, -1));                    // off-sphere
        add_tri({9{16'hAAAA}});
        add_tri({9{16'h5555}});
        add_tri({9{16'hFFFF}});
        add_tri(make_tri(11585, 11585, 0, 0, 11585, 11585,
                         11585, 0, 11585));
        add_tri(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));     // tiny
        drain();

        // Unmapped index must leave both modes alone.
        write_reg(CFG_UNMAPPED, 1'b0);
        add_tri(make_tri(u, 0, 0, 0, u, 0, 0, 0, u));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(sts_pkg::CFG_SUBDIV, phase[0] ? 1'b0 : 1'b1);
            write_reg(sts_pkg::CFG_SMOOTH, phase[1]);
            add_tri(make_tri(u, 0, 0, 0, u, 0, 0, 0, u));
            add_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
            repeat (26)
                add_tri(random_tri());
            drain();
        end

        $display("Sent %0d triangles and checked %0d vertices across all four mode",
                 tris_sent, verts_seen);
        $display("settings, including degenerate faces and opposite edge endpoints.");
        if (errors == 0)
            $display("sphere_triangle_subdivider verification clean");
        else
            $display("sphere_triangle_subdivider verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/sts_pkg.sv
design/sts_norm.sv
design/sts_cross.sv
design/sts_serial.sv
design/sphere_triangle_subdivider.sv
design/sts_checker.sv
bench/sphere_triangle_subdivider_tb.sv
